// ----- design/pdh_pkg.sv -----
// Shared types, codes and helpers for the pair distance histogram.
`default_nettype none
package pdh_pkg;

  localparam int CompWidth = 21;
  localparam int VecWidth  = 63;
  localparam int CfgIdxW   = 3;

  typedef enum logic [2:0] {
    REG_CELL_A  = 3'd0,
    REG_CELL_B  = 3'd1,
    REG_CELL_C  = 3'd2,
    REG_RECIP_A = 3'd3,
    REG_RECIP_B = 3'd4,
    REG_RECIP_C = 3'd5,
    REG_SCALE   = 3'd6,
    REG_CUTOFF  = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_PMUL,
    ST_PACC,
    ST_PFOLD,
    ST_BMUL,
    ST_BACC,
    ST_BCHK,
    ST_SMUL,
    ST_SACC,
    ST_CMP,
    ST_SQRT,
    ST_BINM,
    ST_BINC,
    ST_RD,
    ST_WR,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_PMUL,
    OP_PACC,
    OP_PFOLD,
    OP_BMUL,
    OP_BCHK,
    OP_SMUL,
    OP_SACC,
    OP_CMP,
    OP_SQRT,
    OP_BINM,
    OP_BINC,
    OP_RD,
    OP_WR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] row;
    logic [1:0] comp;
    logic       done;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_read;
    logic type_ok;
    logic rbin_ok;
    logic huge;
    logic over_cut;
    logic beyond;
    logic sq_last;
    logic out_busy;
  } stat_t;

  function automatic logic signed [CompWidth-1:0] comp_of(input logic [VecWidth-1:0] v,
                                                         input logic [1:0] k);
    logic signed [CompWidth-1:0] c;
    case (k)
      2'd0: c = v[0 +: CompWidth];
      2'd1: c = v[CompWidth +: CompWidth];
      2'd2: c = v[2*CompWidth +: CompWidth];
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- design/pair_distance_histogram.sv -----
// Top level of the pair distance histogram: controller, datapath and histogram memory.
// Usage: configure the cell, reciprocal cell, bin scale and squared cutoff through
// cfg_we/cfg_addr/cfg_data while the block is idle. Each input item is either an atom
// pair to add (in_cmd 0) or a read-and-clear of one histogram entry (in_cmd 1), and
// each item yields exactly one result item on the out_ channel.
// An item is taken when in_valid is high and in_stall is low; one item is worked on
// at a time. An add runs 18 products for the projection and the rebuild plus 3 squares
// on one shared multiplier, each product followed by its accumulation, then 22
// iterations of the digit-by-digit square root, the bin product and a read-modify-write
// of the histogram memory. A read does only the read-modify-write of its entry, and a
// pair dropped by type, cutoff or range check finishes early.
// After reset all TYPES*TYPES*BINS entries (4096 by default) of the histogram memory
// are cleared one entry per cycle, and in_stall stays high meanwhile.
// The result waits in an output register while out_stall is high; the next item is
// accepted meanwhile and finishes once that register has been emptied.
`default_nettype none
module pair_distance_histogram #(
  parameter int TYPES       = 4,
  parameter int BINS        = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [pdh_pkg::CfgIdxW-1:0]  cfg_addr,
  input  wire logic [pdh_pkg::VecWidth-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_cmd,
  input  wire logic signed [20:0]           in_center_x,
  input  wire logic signed [20:0]           in_center_y,
  input  wire logic signed [20:0]           in_center_z,
  input  wire logic signed [20:0]           in_neighbor_x,
  input  wire logic signed [20:0]           in_neighbor_y,
  input  wire logic signed [20:0]           in_neighbor_z,
  input  wire logic [1:0]                   in_first_type,
  input  wire logic [1:0]                   in_second_type,
  input  wire logic [7:0]                   in_read_bin,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_counted,
  output logic                              out_beyond_table,
  output logic [7:0]                        out_bin_index,
  output logic [31:0]                       out_entry_count
);
  import pdh_pkg::*;

  cmd_t  cmd;
  stat_t st;

  pdh_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .st      (st),
    .cmd     (cmd)
  );

  pdh_datapath #(
    .TYPES      (TYPES),
    .BINS       (BINS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .in_cmd          (in_cmd),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_center_z     (in_center_z),
    .in_neighbor_x   (in_neighbor_x),
    .in_neighbor_y   (in_neighbor_y),
    .in_neighbor_z   (in_neighbor_z),
    .in_first_type   (in_first_type),
    .in_second_type  (in_second_type),
    .in_read_bin     (in_read_bin),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_counted     (out_counted),
    .out_beyond_table(out_beyond_table),
    .out_bin_index   (out_bin_index),
    .out_entry_count (out_entry_count)
  );

endmodule
`default_nettype wire

// ----- design/pdh_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module pdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/pdh_ctrl.sv -----
// Controller state machine that sequences the shared datapath for each item.
`default_nettype none
module pdh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pdh_pkg::stat_t st,
  output pdh_pkg::cmd_t      cmd
);
  import pdh_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] row_r, row_nxt;
  logic [1:0] comp_r, comp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      row_r   <= '0;
      comp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      comp_r  <= comp_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    comp_nxt  = comp_r;
    case (state_r)
      ST_CLEAR:  if (st.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_DECODE;
      ST_DECODE: begin
        row_nxt  = '0;
        comp_nxt = '0;
        if (!st.type_ok) begin
          state_nxt = ST_DONE;
        end else if (st.is_read) begin
          state_nxt = st.rbin_ok ? ST_RD : ST_DONE;
        end else begin
          state_nxt = ST_PMUL;
        end
      end
      ST_PMUL:   state_nxt = ST_PACC;
      ST_PACC: begin
        if (comp_r == 2'd2) begin
          comp_nxt  = '0;
          state_nxt = ST_PFOLD;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = ST_PMUL;
        end
      end
      ST_PFOLD: begin
        if (row_r == 2'd2) begin
          row_nxt   = '0;
          state_nxt = ST_BMUL;
        end else begin
          row_nxt   = row_r + 2'd1;
          state_nxt = ST_PMUL;
        end
      end
      ST_BMUL:   state_nxt = ST_BACC;
      ST_BACC: begin
        if (comp_r == 2'd2) begin
          comp_nxt  = '0;
          state_nxt = ST_BCHK;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = ST_BMUL;
        end
      end
      ST_BCHK:   state_nxt = ST_SMUL;
      ST_SMUL:   state_nxt = ST_SACC;
      ST_SACC: begin
        if (row_r == 2'd2) begin
          row_nxt   = '0;
          state_nxt = ST_CMP;
        end else begin
          row_nxt   = row_r + 2'd1;
          state_nxt = ST_BMUL;
        end
      end
      ST_CMP:    state_nxt = (st.huge || st.over_cut) ? ST_DONE : ST_SQRT;
      ST_SQRT:   if (st.sq_last) state_nxt = ST_BINM;
      ST_BINM:   state_nxt = ST_BINC;
      ST_BINC:   state_nxt = st.beyond ? ST_DONE : ST_RD;
      ST_RD:     state_nxt = ST_WR;
      ST_WR:     state_nxt = ST_DONE;
      ST_DONE:   if (!st.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    cmd.row  = row_r;
    cmd.comp = comp_r;
    cmd.done = (state_r == ST_DONE) && !st.out_busy;
    case (state_r)
      ST_CLEAR: cmd.op = OP_CLEAR;
      ST_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
      ST_PMUL:  cmd.op = OP_PMUL;
      ST_PACC:  cmd.op = OP_PACC;
      ST_PFOLD: cmd.op = OP_PFOLD;
      ST_BMUL:  cmd.op = OP_BMUL;
      ST_BACC:  cmd.op = OP_PACC;
      ST_BCHK:  cmd.op = OP_BCHK;
      ST_SMUL:  cmd.op = OP_SMUL;
      ST_SACC:  cmd.op = OP_SACC;
      ST_CMP:   cmd.op = OP_CMP;
      ST_SQRT:  cmd.op = OP_SQRT;
      ST_BINM:  cmd.op = OP_BINM;
      ST_BINC:  cmd.op = OP_BINC;
      ST_RD:    cmd.op = OP_RD;
      ST_WR:    cmd.op = OP_WR;
      default:  cmd.op = OP_NONE;
    endcase
  end

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted while one is in flight");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |=> (state_r != ST_CLEAR))
    else $error("clearing pass restarted outside reset");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR) |-> ($past(state_r) == ST_RD))
    else $error("histogram write without a preceding read");

endmodule
`default_nettype wire

// ----- design/pdh_datapath.sv -----
// Datapath: registers, shared multiplier, square root, histogram update and output.
`default_nettype none
module pdh_datapath #(
  parameter int TYPES       = 4,
  parameter int BINS        = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pdh_pkg::cmd_t                 cmd,
  output pdh_pkg::stat_t                     st,
  input  wire logic                          cfg_we,
  input  wire logic [pdh_pkg::CfgIdxW-1:0]   cfg_addr,
  input  wire logic [pdh_pkg::VecWidth-1:0]  cfg_data,
  input  wire logic                          in_cmd,
  input  wire logic signed [20:0]            in_center_x,
  input  wire logic signed [20:0]            in_center_y,
  input  wire logic signed [20:0]            in_center_z,
  input  wire logic signed [20:0]            in_neighbor_x,
  input  wire logic signed [20:0]            in_neighbor_y,
  input  wire logic signed [20:0]            in_neighbor_z,
  input  wire logic [1:0]                    in_first_type,
  input  wire logic [1:0]                    in_second_type,
  input  wire logic [7:0]                    in_read_bin,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic                               out_counted,
  output logic                               out_beyond_table,
  output logic [7:0]                         out_bin_index,
  output logic [31:0]                        out_entry_count
);
  import pdh_pkg::*;

  localparam int DEPTH = TYPES * TYPES * BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(BINS);
  localparam logic [AW-1:0] TT = AW'(TYPES * TYPES);
  localparam logic [AW-1:0] TN = AW'(TYPES);
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  logic [VecWidth-1:0] cell_r [3];
  logic [VecWidth-1:0] recip_r [3];
  logic [23:0]         scale_r;
  logic [39:0]         cutoff_r;

  logic signed [21:0]  d_r [3];
  logic signed [34:0]  f_r [3];
  logic                cmd_r;
  logic [1:0]          t1_r, t2_r;
  logic [7:0]          rbin_r;

  logic signed [60:0]  prod_r;
  logic signed [59:0]  acc_r;
  logic signed [21:0]  v_r;
  logic                huge_r;
  logic [43:0]         dsq_r;
  logic [44:0]         rem_r, res_r, bit_r;
  logic [BW-1:0]       bin_r;
  logic [AW-1:0]       addr_r;
  logic [AW-1:0]       clr_r;

  logic                res_counted_r, res_beyond_r;
  logic [7:0]          res_bin_r;
  logic [31:0]         res_entry_r;

  logic                out_valid_r;
  logic                out_counted_r, out_beyond_r;
  logic [7:0]          out_bin_r;
  logic [31:0]         out_entry_r;

  logic signed [35:0]  mul_a;
  logic signed [24:0]  mul_b;
  logic signed [21:0]  d_sel;
  logic signed [34:0]  f_sel;
  logic [VecWidth-1:0] rvec_sel, cvec_sel;
  logic signed [20:0]  r_comp, c_comp;
  logic signed [34:0]  f_raw, f_fold;
  logic signed [38:0]  v_full;
  logic [44:0]         trial;
  logic [AW-1:0]       addr_nxt;
  logic [COUNT_WIDTH-1:0] ram_q, inc, sat, wdata;
  logic [63:0]         q_wide;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr;

  always_comb begin
    case (cmd.comp)
      2'd0: begin d_sel = d_r[0]; f_sel = f_r[0]; cvec_sel = cell_r[0]; end
      2'd1: begin d_sel = d_r[1]; f_sel = f_r[1]; cvec_sel = cell_r[1]; end
      2'd2: begin d_sel = d_r[2]; f_sel = f_r[2]; cvec_sel = cell_r[2]; end
      default: begin d_sel = '0; f_sel = '0; cvec_sel = '0; end
    endcase
    case (cmd.row)
      2'd0: rvec_sel = recip_r[0];
      2'd1: rvec_sel = recip_r[1];
      2'd2: rvec_sel = recip_r[2];
      default: rvec_sel = '0;
    endcase
    r_comp = comp_of(rvec_sel, cmd.comp);
    c_comp = comp_of(cvec_sel, cmd.row);
  end

  always_comb begin
    case (cmd.op)
      OP_PMUL: begin
        mul_a = {{14{d_sel[21]}}, d_sel};
        mul_b = {{4{r_comp[20]}}, r_comp};
      end
      OP_BMUL: begin
        mul_a = {f_sel[34], f_sel};
        mul_b = {{4{c_comp[20]}}, c_comp};
      end
      OP_SMUL: begin
        mul_a = {{14{v_r[21]}}, v_r};
        mul_b = {{3{v_r[21]}}, v_r};
      end
      OP_BINM: begin
        mul_a = {13'd0, res_r[22:0]};
        mul_b = {1'b0, scale_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    f_raw = 35'(acc_r >>> 10);
    if (f_raw > 35'sd262144) begin
      f_fold = f_raw - 35'sd524288;
    end else if (f_raw < -35'sd262144) begin
      f_fold = f_raw + 35'sd524288;
    end else begin
      f_fold = f_raw;
    end
    v_full = 39'(acc_r >>> 19);
    trial  = res_r + bit_r;
  end

  always_comb begin
    if (cmd_r) begin
      addr_nxt = AW'(AW'(rbin_r) * TT + AW'(t1_r) * TN + AW'(t2_r));
    end else begin
      addr_nxt = AW'(AW'(bin_r) * TT + AW'(t1_r) * TN + AW'(t2_r));
    end
    inc    = (t1_r == t2_r) ? COUNT_WIDTH'(2) : COUNT_WIDTH'(1);
    sat    = (ram_q > CMAX - inc) ? CMAX : ram_q + inc;
    q_wide = 64'(ram_q);
    wdata  = (cmd.op == OP_WR && !cmd_r) ? sat : '0;
    ram_we = (cmd.op == OP_CLEAR) || (cmd.op == OP_WR);
    ram_re = (cmd.op == OP_RD);
    ram_waddr = (cmd.op == OP_CLEAR) ? clr_r : addr_r;
  end

  pdh_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wdata),
    .re   (ram_re),
    .raddr(addr_nxt),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r[0]  <= '0;
      cell_r[1]  <= '0;
      cell_r[2]  <= '0;
      recip_r[0] <= '0;
      recip_r[1] <= '0;
      recip_r[2] <= '0;
      scale_r    <= 24'd65536;
      cutoff_r   <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_CELL_A:  cell_r[0]  <= cfg_data;
        REG_CELL_B:  cell_r[1]  <= cfg_data;
        REG_CELL_C:  cell_r[2]  <= cfg_data;
        REG_RECIP_A: recip_r[0] <= cfg_data;
        REG_RECIP_B: recip_r[1] <= cfg_data;
        REG_RECIP_C: recip_r[2] <= cfg_data;
        REG_SCALE:   scale_r    <= cfg_data[23:0];
        REG_CUTOFF:  cutoff_r   <= cfg_data[39:0];
        default:     scale_r    <= scale_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cmd.done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      OP_LOAD: begin
        d_r[0]        <= 22'(in_center_x) - 22'(in_neighbor_x);
        d_r[1]        <= 22'(in_center_y) - 22'(in_neighbor_y);
        d_r[2]        <= 22'(in_center_z) - 22'(in_neighbor_z);
        cmd_r         <= in_cmd;
        t1_r          <= in_first_type;
        t2_r          <= in_second_type;
        rbin_r        <= in_read_bin;
        acc_r         <= '0;
        dsq_r         <= '0;
        huge_r        <= 1'b0;
        res_counted_r <= 1'b0;
        res_beyond_r  <= 1'b0;
        res_bin_r     <= '0;
        res_entry_r   <= '0;
      end
      OP_PACC: acc_r <= acc_r + 60'(prod_r);
      OP_PFOLD: begin
        case (cmd.row)
          2'd0:    f_r[0] <= f_fold;
          2'd1:    f_r[1] <= f_fold;
          default: f_r[2] <= f_fold;
        endcase
        acc_r <= '0;
      end
      OP_BCHK: begin
        v_r   <= v_full[21:0];
        acc_r <= '0;
        if (v_full >= 39'sd2097152 || v_full <= -39'sd2097152) begin
          huge_r <= 1'b1;
        end
      end
      OP_SACC: dsq_r <= dsq_r + prod_r[43:0];
      OP_CMP: begin
        rem_r <= {1'b0, dsq_r};
        res_r <= '0;
        bit_r <= 45'd1 << 42;
      end
      OP_SQRT: begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_BINC: begin
        bin_r <= prod_r[26 +: BW];
        if (st.beyond) begin
          res_beyond_r <= 1'b1;
        end
      end
      OP_RD: addr_r <= addr_nxt;
      OP_WR: begin
        if (cmd_r) begin
          res_entry_r <= q_wide[31:0];
        end else begin
          res_counted_r <= 1'b1;
          res_bin_r     <= 8'(bin_r);
        end
      end
      default: acc_r <= acc_r;
    endcase
    if (cmd.done) begin
      out_counted_r <= res_counted_r;
      out_beyond_r  <= res_beyond_r;
      out_bin_r     <= res_bin_r;
      out_entry_r   <= res_entry_r;
    end
  end

  always_comb begin
    st.clear_last = (clr_r == AW'(DEPTH - 1));
    st.is_read    = cmd_r;
    st.type_ok    = (32'(t1_r) < TYPES) && (32'(t2_r) < TYPES);
    st.rbin_ok    = (32'(rbin_r) < BINS);
    st.huge       = huge_r;
    st.over_cut   = (dsq_r > {4'd0, cutoff_r});
    st.beyond     = (prod_r[60:26] >= 35'(BINS));
    st.sq_last    = bit_r[0];
    st.out_busy   = out_valid_r && out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_counted      = out_counted_r;
  assign out_beyond_table = out_beyond_r;
  assign out_bin_index    = out_bin_r;
  assign out_entry_count  = out_entry_r;

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Testbench for the pair distance histogram: predicts each result and checks it in order.
`timescale 1ns / 100ps
module tb_top;
  import pdh_pkg::*;

  localparam int NUM_TYPES = 4;
  localparam int NUM_BINS = 256;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic        counted;
    logic        beyond;
    logic [7:0]  bin;
    logic [31:0] count;
  } hist_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_addr = '0;
  logic [VecWidth-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = 1'b0;
  logic signed [20:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic signed [20:0] in_neighbor_x = '0, in_neighbor_y = '0, in_neighbor_z = '0;
  logic [1:0] in_first_type = '0, in_second_type = '0;
  logic [7:0] in_read_bin = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_counted, out_beyond_table;
  logic [7:0] out_bin_index;
  logic [31:0] out_entry_count;

  logic [62:0] cell_vec [3];
  logic [62:0] recip_vec [3];
  logic [23:0] scale_q;
  logic [39:0] cutoff_q;
  logic [31:0] hist_mirror [NUM_TYPES*NUM_TYPES*NUM_BINS];
  hist_result_t pending_results [$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  pair_distance_histogram i_dut (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_data,
    .in_valid, .in_stall, .in_cmd,
    .in_center_x, .in_center_y, .in_center_z,
    .in_neighbor_x, .in_neighbor_y, .in_neighbor_z,
    .in_first_type, .in_second_type, .in_read_bin,
    .out_valid, .out_stall, .out_counted, .out_beyond_table,
    .out_bin_index, .out_entry_count
  );

  function automatic longint vec_comp(logic [62:0] v, int k);
    logic signed [20:0] c;
    c = v[21*k +: 21];
    return longint'(c);
  endfunction

  function automatic longint fold_half(longint f);
    if (f > (64'sd1 <<< 18)) return f - (64'sd1 <<< 19);
    if (f < -(64'sd1 <<< 18)) return f + (64'sd1 <<< 19);
    return f;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Works out the result of one item and applies it to the histogram mirror.
  function automatic hist_result_t bin_pair(logic cmd, longint cx, longint cy, longint cz,
                                            longint nx, longint ny, longint nz,
                                            int t1, int t2, int rbin);
    hist_result_t r;
    longint d [3];
    longint frac [3];
    longint s, v;
    longint unsigned dsq, root_q, bin;
    logic huge;
    int idx;
    r = '0;
    if (cmd) begin
      idx = NUM_TYPES*NUM_TYPES*rbin + t1*NUM_TYPES + t2;
      r.count = hist_mirror[idx];
      hist_mirror[idx] = '0;
      return r;
    end
    d[0] = cx - nx;
    d[1] = cy - ny;
    d[2] = cz - nz;
    for (int j = 0; j < 3; j++) begin
      s = d[0]*vec_comp(recip_vec[j], 0) + d[1]*vec_comp(recip_vec[j], 1)
        + d[2]*vec_comp(recip_vec[j], 2);
      frac[j] = fold_half(s >>> 10);
    end
    huge = 1'b0;
    dsq = 0;
    for (int k = 0; k < 3; k++) begin
      s = frac[0]*vec_comp(cell_vec[0], k) + frac[1]*vec_comp(cell_vec[1], k)
        + frac[2]*vec_comp(cell_vec[2], k);
      v = s >>> 19;
      if (v >= (64'sd1 <<< 21) || v <= -(64'sd1 <<< 21)) huge = 1'b1;
      else dsq = dsq + longint'(v*v);
    end
    if (huge || dsq > cutoff_q) return r;
    root_q = int_sqrt(dsq);
    bin = (root_q * scale_q) >> 26;
    if (bin >= NUM_BINS) begin
      r.beyond = 1'b1;
      return r;
    end
    idx = NUM_TYPES*NUM_TYPES*int'(bin) + t1*NUM_TYPES + t2;
    if (hist_mirror[idx] >= 32'hFFFF_FFFF - ((t1 == t2) ? 1 : 0))
      hist_mirror[idx] = 32'hFFFF_FFFF;
    else
      hist_mirror[idx] = hist_mirror[idx] + ((t1 == t2) ? 2 : 1);
    r.counted = 1'b1;
    r.bin = bin[7:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [62:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    case (idx)
      REG_CELL_A: cell_vec[0] = value;
      REG_CELL_B: cell_vec[1] = value;
      REG_CELL_C: cell_vec[2] = value;
      REG_RECIP_A: recip_vec[0] = value;
      REG_RECIP_B: recip_vec[1] = value;
      REG_RECIP_C: recip_vec[2] = value;
      REG_SCALE: scale_q = value[23:0];
      REG_CUTOFF: cutoff_q = value[39:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [62:0] pack_vec(longint x, longint y, longint z);
    return {z[20:0], y[20:0], x[20:0]};
  endfunction

  task automatic send_item(logic cmd, longint cx, longint cy, longint cz,
                           longint nx, longint ny, longint nz, int t1, int t2, int rbin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_center_x <= cx[20:0];
    in_center_y <= cy[20:0];
    in_center_z <= cz[20:0];
    in_neighbor_x <= nx[20:0];
    in_neighbor_y <= ny[20:0];
    in_neighbor_z <= nz[20:0];
    in_first_type <= t1[1:0];
    in_second_type <= t2[1:0];
    in_read_bin <= rbin[7:0];
    do @(posedge clk); while (in_stall);
    pending_results.push_back(bin_pair(cmd, longint'($signed(cx[20:0])),
      longint'($signed(cy[20:0])), longint'($signed(cz[20:0])),
      longint'($signed(nx[20:0])), longint'($signed(ny[20:0])),
      longint'($signed(nz[20:0])), t1, t2, rbin));
  endtask

  task automatic drain();
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic longint rnd_pos(int span);
    return longint'($urandom_range(2*span)) - span;
  endfunction

  task automatic send_random_pair(int span);
    longint cx, cy, cz;
    cx = rnd_pos(span);
    cy = rnd_pos(span);
    cz = rnd_pos(span);
    send_item(1'b0, cx, cy, cz, cx + rnd_pos(span/2), cy + rnd_pos(span/2),
              cz + rnd_pos(span/2), $urandom_range(3), $urandom_range(3), 0);
  endtask

  task automatic send_random_mix(int n, int span);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0, 1: send_item(1'b0, rnd_pos(1048576), rnd_pos(1048576), rnd_pos(1048576),
                        rnd_pos(1048576), rnd_pos(1048576), rnd_pos(1048576),
                        $urandom_range(3), $urandom_range(3), $urandom_range(255));
        2, 3, 4: send_item(1'b1, rnd_pos(1048576), rnd_pos(1048576), rnd_pos(1048576),
                           rnd_pos(1048576), rnd_pos(1048576), rnd_pos(1048576),
                           $urandom_range(3), $urandom_range(3),
                           $urandom_range(1) ? $urandom_range(40) : $urandom_range(255));
        default: send_random_pair(span);
      endcase
    end
  endtask

  // A cubic cell of side 8.0 with 32 bins per unit and a cutoff of 4.0.
  task automatic set_cubic_cell();
    write_reg(REG_CELL_A, pack_vec(8192, 0, 0));
    write_reg(REG_CELL_B, pack_vec(0, 8192, 0));
    write_reg(REG_CELL_C, pack_vec(0, 0, 8192));
    write_reg(REG_RECIP_A, pack_vec(65536, 0, 0));
    write_reg(REG_RECIP_B, pack_vec(0, 65536, 0));
    write_reg(REG_RECIP_C, pack_vec(0, 0, 65536));
    write_reg(REG_SCALE, 63'(32 * 65536));
    write_reg(REG_CUTOFF, 63'(16 << 20));
  endtask

  task automatic test_reset_config();
    send_item(1'b0, 1000, -2000, 3000, -1048576, 1048575, 0, 1, 1, 0);
    send_item(1'b0, 5, 5, 5, 5, 5, 5, 2, 3, 0);
    send_item(1'b1, 0, 0, 0, 0, 0, 0, 1, 1, 0);
    drain();
  endtask

  task automatic test_directed();
    set_cubic_cell();
    send_item(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(1'b0, 1024, 0, 0, 0, 0, 0, 3, 2, 0);
    send_item(1'b0, 4096, 0, 0, 0, 0, 0, 1, 1, 0);
    send_item(1'b0, 4097, 0, 0, 0, 0, 0, 1, 1, 0);
    send_item(1'b0, 0, 0, 0, 4097, 0, 0, 1, 1, 0);
    send_item(1'b0, 7000, 0, 0, 0, 0, 0, 2, 2, 0);
    send_item(1'b0, 3000, 3000, 0, 0, 0, 0, 0, 1, 0);
    send_item(1'b0, 1000, 1000, 1000, 0, 0, 0, 2, 0, 0);
    send_item(1'b0, 1048575, 1048575, 1048575, -1048576, -1048576, -1048576, 3, 3, 0);
    send_item(1'b0, -1048576, 0, 1048575, 1048575, 0, -1048576, 0, 3, 0);
    send_item(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(1'b1, 0, 0, 0, 0, 0, 0, 3, 2, 32);
    send_item(1'b1, 0, 0, 0, 0, 0, 0, 3, 3, 255);
    send_item(1'b1, -1, -1, -1, -1, -1, -1, 1, 1, 128);
    drain();
    write_reg(REG_CUTOFF, 63'(40'hFF_FFFF_FFFF));
    write_reg(REG_SCALE, 63'(24'hFF_FFFF));
    send_item(1'b0, 4096, 4096, 4096, 0, 0, 0, 1, 2, 0);
    send_item(1'b0, 1, 0, 0, 0, 0, 0, 1, 2, 0);
    drain();
    write_reg(REG_SCALE, 63'd0);
    send_item(1'b0, 4096, 4096, 4096, 0, 0, 0, 2, 1, 0);
    drain();
    write_reg(REG_CELL_A, pack_vec(-1048576, 1048575, -1048576));
    write_reg(REG_RECIP_A, pack_vec(1048575, -1048576, 1048575));
    send_item(1'b0, 9000, -7000, 5000, 0, 0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_random_phases();
    int idle_set [4] = '{0, 48, 0, 7};
    int stall_set [4] = '{0, 0, 48, 7};
    int side, shear;
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      side = 4096 * (1 + p);
      shear = $urandom_range(side / 2);
      write_reg(REG_CELL_A, pack_vec(side, 0, 0));
      write_reg(REG_CELL_B, pack_vec(shear, side, 0));
      write_reg(REG_CELL_C, pack_vec(0, shear, side));
      write_reg(REG_RECIP_A, pack_vec((1 << 29) / side, -longint'((1 << 29) / side) / 4, 0));
      write_reg(REG_RECIP_B, pack_vec(0, (1 << 29) / side, 0));
      write_reg(REG_RECIP_C, pack_vec(0, 0, (1 << 29) / side));
      write_reg(REG_SCALE, 63'($urandom_range(1 << 22)));
      write_reg(REG_CUTOFF, 63'(longint'(side) * side / 4 + $urandom_range(1 << 20)));
      send_random_mix(90, side);
      drain();
    end
  endtask

  task automatic test_random_registers();
    idle_pct = 7;
    stall_pct = 7;
    for (int p = 0; p < 2; p++) begin
      for (int r = 0; r < 8; r++)
        write_reg(reg_idx_t'(r), 63'({$urandom(), $urandom()}));
      send_random_mix(25, 1048575);
      drain();
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    hist_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_counted !== want.counted) report_mismatch("counted", out_counted, want.counted);
        if (out_beyond_table !== want.beyond)
          report_mismatch("beyond_table", out_beyond_table, want.beyond);
        if (out_bin_index !== want.bin) report_mismatch("bin_index", out_bin_index, want.bin);
        if (out_entry_count !== want.count)
          report_mismatch("entry_count", out_entry_count, want.count);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cell_vec = '{default: '0};
    recip_vec = '{default: '0};
    scale_q = 24'd65536;
    cutoff_q = '0;
    foreach (hist_mirror[i]) hist_mirror[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_directed();
    test_random_phases();
    test_random_registers();
    if (pending_results.size() != 0) report_mismatch("results left over", 0, 0);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/pdh_pkg.sv
design/pdh_ram.sv
design/pdh_ctrl.sv
design/pdh_datapath.sv
design/pair_distance_histogram.sv
dv/tb_top.sv
